[rtl/b64d_pkg.sv]
`default_nettype none

package b64d_pkg;

    // Character that stands for one pad in a group
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Job queue between the front and the back
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_error;
        logic       run_last;
    } out_word_t;

    typedef enum logic {
        JOB_BYTES,
        JOB_ERROR
    } job_kind_t;

    // One queued job: a finished group with its byte count, or an error word
    typedef struct packed {
        job_kind_t   kind;
        logic [1:0]  nbytes;
        logic [23:0] group;
    } job_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    // Map one character through the standard alphabet
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t r;
        r.valid = 1'b1;
        r.value = '0;
        priority if (c >= 8'h41 && c <= 8'h5A) begin
            r.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.value = 6'(c - 8'h47);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 6'(c + 8'h04);
        end else if (c == 8'h2B) begin
            r.value = 6'd62;
        end else if (c == 8'h2F) begin
            r.value = 6'd63;
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/b64d_front.sv]
`default_nettype none

module b64d_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire b64d_pkg::in_word_t s_data,
    input  wire logic             queue_full,
    output logic                  push,
    output b64d_pkg::job_t        push_job
);
    import b64d_pkg::*;

    logic [23:0] group_reg, group_next;
    logic [1:0]  chars_reg, chars_next;
    logic [2:0]  pads_reg, pads_next;
    logic        latched_reg, latched_next;

    logic        accept;
    logic        is_pad;
    logic        err;
    sextet_t     sx;
    logic [2:0]  pads_inc;
    logic [23:0] group_ins;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    // Classify the character and place its sextet in the group
    always_comb begin
        is_pad    = (s_data.char_code == PAD_CHAR);
        sx        = sextet_of(s_data.char_code);
        pads_inc  = is_pad ? pads_reg + 3'd1 : pads_reg;
        group_ins = group_reg;
        if (!is_pad && sx.valid) begin
            unique case (chars_reg)
                2'd0:    group_ins[23:18] = sx.value;
                2'd1:    group_ins[17:12] = sx.value;
                2'd2:    group_ins[11:6]  = sx.value;
                default: group_ins[5:0]   = sx.value;
            endcase
        end
    end

    // Decide the job and the next group state
    always_comb begin
        err            = !is_pad && !sx.valid;
        push           = 1'b0;
        push_job.kind  = JOB_BYTES;
        push_job.nbytes = 2'd3 - pads_inc[1:0];
        push_job.group = group_ins;
        group_next     = group_reg;
        chars_next     = chars_reg;
        pads_next      = pads_reg;
        latched_next   = latched_reg;

        if (accept) begin
            if (latched_reg) begin
                // drop words until message end
            end else begin
                if (!err) begin
                    if (chars_reg == 2'd3) begin
                        if (pads_inc > 3'd2) begin
                            err = 1'b1;
                        end else begin
                            push = 1'b1;
                        end
                        group_next = '0;
                        chars_next = '0;
                        pads_next  = '0;
                    end else begin
                        group_next = group_ins;
                        chars_next = chars_reg + 2'd1;
                        pads_next  = pads_inc;
                        if (s_data.end_of_message) begin
                            err = 1'b1;
                        end
                    end
                end
                if (err) begin
                    push          = 1'b1;
                    push_job.kind = JOB_ERROR;
                    group_next    = '0;
                    chars_next    = '0;
                    pads_next     = '0;
                    latched_next  = 1'b1;
                end
            end
            // message end returns everything to reset
            if (s_data.end_of_message) begin
                group_next   = '0;
                chars_next   = '0;
                pads_next    = '0;
                latched_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_reg   <= '0;
            chars_reg   <= '0;
            pads_reg    <= '0;
            latched_reg <= 1'b0;
        end else begin
            group_reg   <= group_next;
            chars_reg   <= chars_next;
            pads_reg    <= pads_next;
            latched_reg <= latched_next;
        end
    end

    // Every character is either a pad or a sextet, so pads never outrun chars
    a_pads_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pads_reg <= {1'b0, chars_reg})
        else $error("pad count exceeds character count");

    // A message end leaves the group empty and the error latch clear
    a_eom_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.end_of_message |=>
            chars_reg == 2'd0 && pads_reg == 3'd0 && !latched_reg)
        else $error("state not cleared after message end");

    // Nothing is queued while input is being dropped
    a_no_push_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        latched_reg |-> !push)
        else $error("job queued while dropping input");

endmodule

`default_nettype wire

[rtl/b64d_queue.sv]
`default_nettype none

module b64d_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire b64d_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output b64d_pkg::job_t      head_job
);
    import b64d_pkg::*;

    job_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = entries_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold job payloads
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointer distance always matches the fill count
    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        QUEUE_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_AW-1:0])
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[rtl/b64d_back.sv]
`default_nettype none

module b64d_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           empty,
    input  wire b64d_pkg::job_t head_job,
    output logic                pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output b64d_pkg::out_word_t m_data
);
    import b64d_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       take;
    logic       last;

    assign m_valid = !empty;
    assign take    = m_valid && m_ready;

    // Select the byte of the head job and mark its last word
    always_comb begin
        m_data.is_error = 1'b0;
        m_data.run_last = 1'b0;
        m_data.data_byte = '0;
        last = (idx_reg == head_job.nbytes - 2'd1);
        if (head_job.kind == JOB_ERROR) begin
            m_data.is_error = 1'b1;
            last = 1'b1;
        end else begin
            unique case (idx_reg)
                2'd0:    m_data.data_byte = head_job.group[23:16];
                2'd1:    m_data.data_byte = head_job.group[15:8];
                default: m_data.data_byte = head_job.group[7:0];
            endcase
        end
        m_data.run_last = last;
        pop = take && last;
    end

    // Advance the byte index, drop back to zero when the job retires
    always_comb begin
        idx_next = idx_reg;
        if (pop) begin
            idx_next = '0;
        end else if (take) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    // The byte index stays within the job being sent
    a_idx_in_job: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && head_job.kind == JOB_BYTES |-> idx_reg < head_job.nbytes)
        else $error("byte index beyond job");

endmodule

`default_nettype wire

[rtl/base64_decoder_top.sv]
// Jobs are registered into the queue; m_ is driven from the queue head combinationally.
// Throughput: one character per cycle while the queue has room; one byte out per ready
// cycle, so a group (four characters, at most three bytes) backs up input only on stalls.
// A four-job queue between front and back absorbs output stalls; s_ready falls when it fills.
// Reset: synchronous, active low; clears group state, error latch and queue.
`default_nettype none

module base64_decoder_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire b64d_pkg::in_word_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output b64d_pkg::out_word_t     m_data
);
    import b64d_pkg::*;

    logic push;
    job_t push_job;
    logic full;
    logic pop;
    logic empty;
    job_t head_job;

    b64d_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .queue_full (full),
        .push       (push),
        .push_job   (push_job)
    );

    b64d_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head_job (head_job)
    );

    b64d_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .head_job (head_job),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

[tb/base64_decoder_top_tb.sv]
`default_nettype none

module base64_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_CHARS   = 210;
    localparam int NOISE_CHARS    = 70;
    localparam int MAX_PRINTED    = 40;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    base64_decoder_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Decoder state as predicted from the accepted characters
    logic [23:0] grp_bits  = '0;
    logic [1:0]  grp_chars = '0;
    logic [2:0]  grp_pads  = '0;
    logic        drop_mode = 1'b0;

    out_word_t expected_bytes[$];

    int unsigned cycle_count     = 0;
    int          mismatch_count  = 0;
    int          chars_sent      = 0;
    int          live_chars      = 0;
    int          words_checked   = 0;
    int          error_words     = 0;
    int          messages_sent   = 0;
    int          burst_left      = 0;
    int          stall_style     = 0;
    int          stall_left      = 0;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending",
                     cycle_count, expected_bytes.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Lookup into the standard alphabet: bit 6 set means not in the alphabet
    function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) return {1'b0, 6'(c - 8'h41)};
        if (c >= 8'h61 && c <= 8'h7A) return {1'b0, 6'(c - 8'h61 + 8'd26)};
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, 6'(c - 8'h30 + 8'd52)};
        if (c == 8'h2B) return {1'b0, 6'd62};
        if (c == 8'h2F) return {1'b0, 6'd63};
        return {1'b1, 6'd0};
    endfunction

    // Character for a sextet value
    function automatic logic [7:0] alpha_char(input int idx);
        if (idx < 26) return 8'(8'h41 + idx);
        if (idx < 52) return 8'(8'h61 + idx - 26);
        if (idx < 62) return 8'(8'h30 + idx - 52);
        return (idx == 62) ? 8'h2B : 8'h2F;
    endfunction

    function automatic logic [7:0] invalid_char();
        logic [7:0] c;
        logic [6:0] sx;
        do begin
            c  = 8'($urandom_range(0, 255));
            sx = sextet_lookup(c);
        end while (!sx[6] || c == PAD_CHAR);
        return c;
    endfunction

    function automatic void push_word(input logic [7:0] b, input logic e, input logic l);
        out_word_t w;
        w.data_byte = b;
        w.is_error  = e;
        w.run_last  = l;
        expected_bytes.insert(expected_bytes.size(), w);
        if (e) error_words++;
    endfunction

    function automatic void clear_group();
        grp_bits  = '0;
        grp_chars = '0;
        grp_pads  = '0;
    endfunction

    // Advance the decoder by one character and queue the words it produces
    function automatic void decode_char(input logic [7:0] c, input logic eom);
        logic [6:0] sx;
        logic       bad;
        bad = 1'b0;
        if (drop_mode) begin
            if (eom) begin
                clear_group();
                drop_mode = 1'b0;
            end
            return;
        end
        live_chars++;
        if (c == PAD_CHAR) begin
            grp_pads = grp_pads + 3'd1;
        end else begin
            sx = sextet_lookup(c);
            if (sx[6]) begin
                bad = 1'b1;
            end else begin
                grp_bits = grp_bits | (24'(sx[5:0]) << (6 * (3 - int'(grp_chars))));
            end
        end
        if (!bad) begin
            if (grp_chars == 2'd3) begin
                case (grp_pads)
                    3'd0: begin
                        push_word(grp_bits[23:16], 1'b0, 1'b0);
                        push_word(grp_bits[15:8],  1'b0, 1'b0);
                        push_word(grp_bits[7:0],   1'b0, 1'b1);
                    end
                    3'd1: begin
                        push_word(grp_bits[23:16], 1'b0, 1'b0);
                        push_word(grp_bits[15:8],  1'b0, 1'b1);
                    end
                    3'd2: begin
                        push_word(grp_bits[23:16], 1'b0, 1'b1);
                    end
                    default: bad = 1'b1;
                endcase
                clear_group();
            end else begin
                grp_chars = grp_chars + 2'd1;
                if (eom) bad = 1'b1;
            end
        end
        if (bad) begin
            push_word(8'h00, 1'b1, 1'b1);
            clear_group();
            if (!eom) drop_mode = 1'b1;
        end
        if (eom) begin
            clear_group();
            drop_mode = 1'b0;
        end
    endfunction

    // Send one character word; bursts of random length with random gaps between
    task automatic send_char(input logic [7:0] c, input logic eom);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{char_code: c, end_of_message: eom};
        do begin
            @(posedge aclk);
        end while (!s_ready);
        decode_char(c, eom);
        chars_sent++;
        if (eom) messages_sent++;
        burst_left--;
    endtask

    task automatic send_string(input string s, input logic eom_on_last);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], eom_on_last && (i == s.len() - 1));
        end
    endtask

    // Receiver stalls: phases of always-ready, coin flip, mostly stalled, periodic
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(20, 80);
        end
        stall_left = stall_left - 1;
        case (stall_style)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= (cycle_count % 5 != 0);
        endcase
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTED) begin
            $display("[%0t] word %0d: %s is %0h, expected %0h",
                     $realtime, words_checked, what, got, want);
        end
        mismatch_count++;
    endtask

    // Compare each taken result word with the oldest prediction
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected word", int'(m_data), 0);
            end else begin
                want = expected_bytes.pop_front();
                if (m_data.data_byte !== want.data_byte)
                    report_mismatch("data_byte", int'(m_data.data_byte),
                                    int'(want.data_byte));
                if (m_data.is_error !== want.is_error)
                    report_mismatch("is_error", int'(m_data.is_error),
                                    int'(want.is_error));
                if (m_data.run_last !== want.run_last)
                    report_mismatch("run_last", int'(m_data.run_last),
                                    int'(want.run_last));
            end
            words_checked++;
        end
    end

    // Full groups with 0, 1 and 2 pads, alphabet extremes, pads out of place
    task automatic test_valid_groups();
        send_string("Az+/Za9=", 1'b1);
        send_string("0==A", 1'b1);
    endtask

    // Too many pads, bad bytes with drop to end, bad byte ending a partial group
    task automatic test_error_cases();
        send_string("T===", 1'b1);
        send_string("====", 1'b1);
        send_char(8'h80, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h51, 1'b1);
        send_char(8'h51, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    // Mostly well-formed messages; the rest broken by a bad byte, truncation or stray pads
    task automatic test_random_messages();
        logic [7:0] msg[$];
        int         groups;
        int         npad;
        int         flavor;
        int         pos;
        while (chars_sent < 25 + RANDOM_CHARS) begin
            msg.delete();
            groups = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
            flavor = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            npad   = $urandom_range(0, 2);
            for (int g = 0; g < groups; g++) begin
                for (int p = 0; p < 4; p++) begin
                    if (flavor == 3 && $urandom_range(0, 2) == 0)
                        msg.insert(msg.size(), PAD_CHAR);
                    else if (g == groups - 1 && p >= 4 - npad && flavor != 3)
                        msg.insert(msg.size(), PAD_CHAR);
                    else
                        msg.insert(msg.size(), alpha_char($urandom_range(0, 63)));
                end
            end
            if (flavor == 1) begin
                pos = $urandom_range(0, msg.size() - 1);
                msg[pos] = invalid_char();
            end else if (flavor == 2) begin
                repeat ($urandom_range(1, 3)) void'(msg.pop_back());
            end
            foreach (msg[i]) send_char(msg[i], i == msg.size() - 1);
        end
    endtask

    // Unstructured bytes with random message ends
    task automatic test_noise();
        logic [7:0] c;
        int         start;
        start = chars_sent;
        while (chars_sent - start < NOISE_CHARS) begin
            case ($urandom_range(0, 3))
                0:       c = PAD_CHAR;
                1:       c = 8'($urandom_range(0, 255));
                default: c = alpha_char($urandom_range(0, 63));
            endcase
            send_char(c, $urandom_range(0, 5) == 0);
        end
        send_char(alpha_char($urandom_range(0, 63)), 1'b1);
    endtask

    initial begin
        // Hold reset, release on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_valid_groups();
        test_error_cases();
        test_random_messages();
        test_noise();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d characters in %0d messages (%0d decoded, rest dropped).",
                 chars_sent, messages_sent, live_chars);
        $display("Checked %0d output words, %0d of them error words.",
                 words_checked, error_words);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_decoder_top.sv
tb/base64_decoder_top_tb.sv
